/* rtl/bitmap_block_allocator_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap block allocator
// Shared same-cycle-implication and next-cycle-implication checks.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define BBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap allocator check failed");

// next-cycle implication, disabled in reset
`define BBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap allocator check failed");

`endif

/* rtl/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg
// Types, sizes and codes shared by the bitmap block allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    localparam int MAX_BLOCKS = 4096;
    localparam int WORD_BITS  = 8;
    localparam int NUM_WORDS  = MAX_BLOCKS / WORD_BITS;
    localparam int WADDR_W    = $clog2(NUM_WORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int BLK_W      = 12;
    localparam int CNT_W      = 13;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [WADDR_W-1:0]   waddr_t;
    typedef logic [BIT_W-1:0]     bitidx_t;
    typedef logic [BLK_W-1:0]     blk_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    localparam cnt_t   TOTAL_RESET = cnt_t'(MAX_BLOCKS);
    localparam waddr_t LAST_WORD   = waddr_t'(NUM_WORDS - 1);

    // register index of total_blocks
    localparam logic REG_TOTAL_BLOCKS = 1'b0;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_FULL        = 2'd1,
        ST_DOUBLE_FREE = 2'd2,
        ST_RANGE       = 2'd3
    } status_t;

    // bitmap RAM request: one write and one read address per cycle
    typedef struct packed {
        logic   we;
        waddr_t waddr;
        word_t  wdata;
        waddr_t raddr;
    } ram_req_t;

    // index of the lowest set bit; zero when none is set
    function automatic bitidx_t lowest_set(input word_t w);
        bitidx_t idx;
        idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (w[b]) begin
                idx = bitidx_t'(b);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

/* rtl/bba_ram.sv */
// ----------------------------------------------------------------------------
// bba_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/bba_regs.sv */
// ----------------------------------------------------------------------------
// bba_regs
// APB register file: total_blocks, and the effective block count derived.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_regs
    import bba_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output cnt_t                   lim
);

    cnt_t total_reg;
    cnt_t total_next;
    logic wr_en;

    // index is paddr[2]; byte lanes ignored
    assign wr_en = psel && penable && pwrite && (paddr[2] == REG_TOTAL_BLOCKS);

    always_comb
    begin
        total_next = total_reg;
        if (wr_en)
        begin
            total_next = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_RESET;
        end
        else
        begin
            total_reg <= total_next;
        end
    end

    assign prdata = (paddr[2] == REG_TOTAL_BLOCKS) ? APB_DW'(total_reg) : '0;
    assign pready = 1'b1;

    // counts above capacity act as capacity
    assign lim = (total_reg > TOTAL_RESET) ? TOTAL_RESET : total_reg;

endmodule

`default_nettype wire

/* rtl/bba_engine.sv */
// ----------------------------------------------------------------------------
// bba_engine
// Request sequencer: clears the bitmap, scans for a free block, frees blocks.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmap_block_allocator_top_macros.svh"

module bba_engine
    import bba_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cnt_t  lim,
    input  wire logic  req_valid,
    output logic       req_stall,
    input  wire logic  func,
    input  wire blk_t  block_number,
    output logic       rsp_valid,
    input  wire logic  rsp_stall,
    output blk_t       granted_block,
    output status_t    status,
    output ram_req_t   ram_req,
    input  wire word_t ram_rdata
);

    typedef enum logic [4:0] {
        S_CLEAR    = 5'b00001,
        S_IDLE     = 5'b00010,
        S_SCAN     = 5'b00100,
        S_FREE_CHK = 5'b01000,
        S_DONE     = 5'b10000
    } state_t;

    state_t  state_reg, state_next;
    waddr_t  addr_reg, addr_next;      // clear pointer / word under check
    blk_t    blk_reg, blk_next;
    blk_t    res_blk_reg, res_blk_next;
    status_t res_st_reg, res_st_next;
    logic    rsp_valid_reg, rsp_valid_next;
    blk_t    out_blk_reg, out_blk_next;
    status_t out_st_reg, out_st_next;

    logic    accept;
    blk_t    lim_m1;
    waddr_t  last_word;
    word_t   vmask;
    word_t   free_bits;
    logic    hit;
    bitidx_t hit_idx;
    logic    out_free;

    assign accept    = req_valid && (state_reg == S_IDLE);
    assign req_stall = (state_reg != S_IDLE);
    assign lim_m1    = blk_t'(lim - cnt_t'(1));
    assign last_word = lim_m1[BLK_W-1:BIT_W];
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // bits of the checked word that lie below the count
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            vmask[b] = (addr_reg < last_word) || (bitidx_t'(b) <= lim_m1[BIT_W-1:0]);
        end
    end

    assign free_bits = ~ram_rdata & vmask;
    assign hit       = |free_bits;
    assign hit_idx   = lowest_set(free_bits);

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        blk_next       = blk_reg;
        res_blk_next   = res_blk_reg;
        res_st_next    = res_st_reg;
        rsp_valid_next = rsp_valid_reg;
        out_blk_next   = out_blk_reg;
        out_st_next    = out_st_reg;
        ram_req        = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = addr_reg;
                ram_req.wdata = '0;
                addr_next     = addr_reg + waddr_t'(1);
                if (addr_reg == LAST_WORD)
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                ram_req.raddr = (func == FUNC_ALLOC) ? '0 : block_number[BLK_W-1:BIT_W];
                if (accept)
                begin
                    res_blk_next = '0;
                    blk_next     = block_number;
                    addr_next    = '0;
                    if (func == FUNC_ALLOC)
                    begin
                        if (lim == '0)
                        begin
                            res_st_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if (cnt_t'(block_number) >= lim)
                    begin
                        res_st_next = ST_RANGE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FREE_CHK;
                    end
                end
            end
            S_SCAN:
            begin
                // read one word ahead while checking the current one
                ram_req.raddr = addr_reg + waddr_t'(1);
                addr_next     = addr_reg + waddr_t'(1);
                if (hit)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = addr_reg;
                    ram_req.wdata = ram_rdata | (word_t'(1) << hit_idx);
                    res_blk_next  = {addr_reg, hit_idx};
                    res_st_next   = ST_OK;
                    state_next    = S_DONE;
                end
                else if (addr_reg == last_word)
                begin
                    res_st_next = ST_FULL;
                    state_next  = S_DONE;
                end
            end
            S_FREE_CHK:
            begin
                if (!ram_rdata[blk_reg[BIT_W-1:0]])
                begin
                    res_st_next = ST_DOUBLE_FREE;
                end
                else
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = blk_reg[BLK_W-1:BIT_W];
                    ram_req.wdata = ram_rdata & ~(word_t'(1) << blk_reg[BIT_W-1:0]);
                    res_st_next   = ST_OK;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    out_blk_next   = res_blk_reg;
                    out_st_next    = res_st_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg     <= blk_next;
        res_blk_reg <= res_blk_next;
        res_st_reg  <= res_st_next;
        out_blk_reg <= out_blk_next;
        out_st_reg  <= out_st_next;
    end

    assign rsp_valid     = rsp_valid_reg;
    assign granted_block = out_blk_reg;
    assign status        = out_st_reg;

    `BBA_ASSERT_IMP(a_no_write_idle, clk, rst_n,
        (state_reg == S_IDLE) || (state_reg == S_DONE), !ram_req.we)
    `BBA_ASSERT_IMP(a_scan_in_range, clk, rst_n,
        state_reg == S_SCAN, addr_reg <= last_word)
    `BBA_ASSERT_IMP(a_grant_below_lim, clk, rst_n,
        (state_reg == S_SCAN) && hit, cnt_t'({addr_reg, hit_idx}) < lim)
    `BBA_ASSERT_NXT(a_clear_ends, clk, rst_n,
        (state_reg == S_CLEAR) && (addr_reg == LAST_WORD), state_reg == S_IDLE)

endmodule

`default_nettype wire

/* rtl/bitmap_block_allocator_top.sv */
// ----------------------------------------------------------------------------
// bitmap_block_allocator_top
// First-fit bitmap block allocator with an APB count register.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  request   req_valid / req_stall     func, block_number
//  response  rsp_valid / rsp_stall     granted_block, status
//  config    psel/penable/pwrite       paddr, pwdata (prdata on read)
//
//  Flow: a free goes from accept through S_FREE_CHK and S_DONE to the
//  response register. An allocate scans in S_SCAN from word 0 up to the word
//  holding the first free block (at most word (total_blocks-1)/8 of 512); the
//  bitmap RAM gives one word a cycle. Reset: a clearing pass writes all 512
//  bitmap words with req_stall high; config writes are taken meanwhile.
//  Stalls: the response register holds a result under rsp_stall; the next
//  request is accepted while it waits, and its result waits in the engine.
//
`default_nettype none

module bitmap_block_allocator_top
    import bba_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // request channel
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire logic              func,
    input  wire logic [BLK_W-1:0]  block_number,
    // response channel
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output logic      [BLK_W-1:0]  granted_block,
    output logic      [1:0]        status,
    // APB config port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    cnt_t     lim;
    ram_req_t ram_req;
    word_t    ram_rdata;
    status_t  status_w;

    // total_blocks register; lim is the count clamped to capacity
    bba_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .lim     (lim)
    );

    // sequencer: clear pass, word scan, read-modify-write of the bitmap
    bba_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .lim           (lim),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .func          (func),
        .block_number  (block_number),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .granted_block (granted_block),
        .status        (status_w),
        .ram_req       (ram_req),
        .ram_rdata     (ram_rdata)
    );

    assign status = status_w;

    // usage bitmap: one bit per block, set = used
    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire
